@@ rtl/core/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler package
// Widths, request and status codes, and the state machine type shared by
// the timer scheduler modules.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int SLOT_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_BITS = $clog2(NUM_TIMERS + 1);
   localparam int ID_BITS = 16;
   localparam int TIME_BITS = 32;
   localparam int PERIOD_BITS = 24;
   localparam int REPEAT_BITS = 16;

   localparam logic [2:0] REQ_TICK = 3'd0;
   localparam logic [2:0] REQ_ADD_PER = 3'd1;
   localparam logic [2:0] REQ_ADD_ONE = 3'd2;
   localparam logic [2:0] REQ_KILL = 3'd3;
   localparam logic [2:0] REQ_QUERY = 3'd4;

   localparam logic [2:0] ST_ADDED = 3'd0;
   localparam logic [2:0] ST_REJECTED = 3'd1;
   localparam logic [2:0] ST_KILLED = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_QUERY = 3'd4;
   localparam logic [2:0] ST_FIRED = 3'd5;

   // One timer table entry as it is held in the slot memory.
   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [TIME_BITS-1:0] fire_time;
      logic [PERIOD_BITS-1:0] period;
      logic [REPEAT_BITS-1:0] remaining;
      logic forever_flag;
   } slot_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WAIT,
      S_DECIDE,
      S_EMIT
   } state_type;

endpackage

@@ rtl/core/multi_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// Multi timer scheduler
// Table of one-shot and periodic timers held in a slot memory, scanned
// slot by slot for each request word.
//
//   channel | direction | handshake
//   req_    | in        | req_valid / req_stall
//   rsp_    | out       | rsp_valid / rsp_stall
//
// A word is accepted only in the idle state. It then visits each slot in turn,
// reading its entry in the scan state and checking or rearming it in the wait
// state, and then answers; the next word is accepted once the answer is done.
// Fired words leave during the scan. Unknown request codes are dropped unanswered.
// Reset empties the table and clears the tick count.
// A stalled result word holds the scan until it is taken.
// ----------------------------------------------------------------------------
module multi_timer_scheduler (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_type,
   input  logic [15:0] req_timer_id,
   input  logic [23:0] req_period,
   input  logic [15:0] req_repeat_count,
   input  logic req_forever_req,
   input  logic [31:0] req_fire_at,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_out_id,
   output logic rsp_present,
   output logic rsp_last
);

   localparam int SB = mts_pkg::SLOT_BITS;
   localparam int TB = mts_pkg::TIME_BITS;

   mts_pkg::state_type state_ff, state_in;

   logic [mts_pkg::NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [TB-1:0] now_ff, now_in;
   logic [2:0] type_ff;
   logic [mts_pkg::ID_BITS-1:0] id_ff;
   logic [23:0] period_ff;
   logic [15:0] count_ff;
   logic forever_ff;
   logic [TB-1:0] at_ff;
   logic [mts_pkg::CNT_BITS-1:0] idx_ff, idx_in;
   logic [SB-1:0] cur_ff, cur_in;
   logic match_ff, match_in;
   logic [SB-1:0] match_slot_ff, match_slot_in;
   logic free_ff, free_in;
   logic [SB-1:0] free_slot_ff, free_slot_in;
   logic any_fired_ff, any_fired_in;
   logic pend_ff, pend_in;
   logic [15:0] pend_id_ff, pend_id_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic rsp_present_ff, rsp_present_in;
   logic rsp_last_ff, rsp_last_in;

   logic wr_en;
   logic [SB-1:0] wr_addr;
   mts_pkg::slot_type wr_data;
   logic [SB-1:0] rd_addr;
   mts_pkg::slot_type rd_data;

   logic req_take, out_free, scan_done, cur_valid, due;

   mts_slot_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != mts_pkg::S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign scan_done = (idx_ff == mts_pkg::CNT_BITS'(mts_pkg::NUM_TIMERS));
   // While a slot is being checked its entry is read again, so a stall keeps it.
   assign rd_addr = (state_ff == mts_pkg::S_WAIT) ? cur_ff : idx_ff[SB-1:0];
   assign cur_valid = valid_ff[cur_ff];
   assign due = cur_valid && (rd_data.fire_time <= now_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mts_pkg::S_IDLE: begin
            if (req_take && req_type <= mts_pkg::REQ_QUERY) state_in = mts_pkg::S_SCAN;
         end
         mts_pkg::S_SCAN: state_in = mts_pkg::S_WAIT;
         mts_pkg::S_WAIT: begin
            if (type_ff == mts_pkg::REQ_TICK) begin
               if (!due || out_free) state_in = scan_done ? mts_pkg::S_EMIT : mts_pkg::S_SCAN;
            end else begin
               state_in = scan_done ? mts_pkg::S_DECIDE : mts_pkg::S_SCAN;
            end
         end
         mts_pkg::S_DECIDE: begin
            if (out_free) state_in = mts_pkg::S_IDLE;
         end
         mts_pkg::S_EMIT: begin
            if (!pend_ff || out_free) state_in = mts_pkg::S_IDLE;
         end
         default: state_in = mts_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      valid_in = valid_ff;
      now_in = now_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      match_in = match_ff;
      match_slot_in = match_slot_ff;
      free_in = free_ff;
      free_slot_in = free_slot_ff;
      any_fired_in = any_fired_ff;
      pend_in = pend_ff;
      pend_id_in = pend_id_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in = rsp_id_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in = rsp_last_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = rd_data;
      unique case (state_ff)
         mts_pkg::S_IDLE: begin
            idx_in = '0;
            match_in = 1'b0;
            free_in = 1'b0;
            match_slot_in = '0;
            free_slot_in = '0;
            any_fired_in = 1'b0;
            pend_in = 1'b0;
            if (req_take && req_type == mts_pkg::REQ_TICK) now_in = now_ff + 1'b1;
         end
         mts_pkg::S_SCAN: begin
            cur_in = idx_ff[SB-1:0];
            idx_in = idx_ff + 1'b1;
         end
         mts_pkg::S_WAIT: begin
            if (type_ff == mts_pkg::REQ_TICK) begin
               // A due slot is rearmed or freed, and its word is held back one
               // step so the final one can carry the last flag.
               if (due && out_free) begin
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = mts_pkg::ST_FIRED;
                     rsp_id_in = pend_id_ff;
                     rsp_present_in = 1'b0;
                     rsp_last_in = 1'b0;
                  end
                  pend_in = 1'b1;
                  pend_id_in = 16'(rd_data.id);
                  if (rd_data.period != '0) begin
                     wr_en = 1'b1;
                     wr_data.fire_time = now_ff + TB'(rd_data.period);
                     if (!rd_data.forever_flag) begin
                        if (rd_data.remaining <= 16'd1) valid_in[cur_ff] = 1'b0;
                        else wr_data.remaining = rd_data.remaining - 1'b1;
                     end
                  end else begin
                     valid_in[cur_ff] = 1'b0;
                  end
               end
            end else begin
               if (cur_valid && rd_data.id == id_ff && !match_ff) begin
                  match_in = 1'b1;
                  match_slot_in = cur_ff;
               end
               if (!cur_valid && !free_ff) begin
                  free_in = 1'b1;
                  free_slot_in = cur_ff;
               end
            end
         end
         mts_pkg::S_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = 16'(id_ff);
               rsp_present_in = 1'b0;
               rsp_last_in = 1'b1;
               priority case (type_ff)
                  mts_pkg::REQ_ADD_PER, mts_pkg::REQ_ADD_ONE: begin
                     if (match_ff || !free_ff ||
                         (type_ff == mts_pkg::REQ_ADD_PER && period_ff == '0) ||
                         (type_ff == mts_pkg::REQ_ADD_ONE && at_ff <= now_ff)) begin
                        rsp_status_in = mts_pkg::ST_REJECTED;
                     end else begin
                        rsp_status_in = mts_pkg::ST_ADDED;
                        valid_in[free_slot_ff] = 1'b1;
                        wr_en = 1'b1;
                        wr_addr = free_slot_ff;
                        wr_data.id = id_ff;
                        if (type_ff == mts_pkg::REQ_ADD_PER) begin
                           wr_data.period = period_ff;
                           wr_data.remaining = count_ff;
                           wr_data.forever_flag = forever_ff;
                           wr_data.fire_time = now_ff + TB'(period_ff);
                        end else begin
                           wr_data.period = '0;
                           wr_data.remaining = 16'd1;
                           wr_data.forever_flag = 1'b0;
                           wr_data.fire_time = at_ff;
                        end
                     end
                  end
                  mts_pkg::REQ_KILL: begin
                     if (match_ff) begin
                        rsp_status_in = mts_pkg::ST_KILLED;
                        valid_in[match_slot_ff] = 1'b0;
                     end else begin
                        rsp_status_in = mts_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     rsp_status_in = mts_pkg::ST_QUERY;
                     rsp_present_in = match_ff;
                  end
               endcase
            end
         end
         mts_pkg::S_EMIT: begin
            if (pend_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = mts_pkg::ST_FIRED;
               rsp_id_in = pend_id_ff;
               rsp_present_in = 1'b0;
               rsp_last_in = 1'b1;
               pend_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mts_pkg::S_IDLE;
         valid_ff <= '0;
         now_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         now_ff <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff <= req_type;
         id_ff <= req_timer_id[mts_pkg::ID_BITS-1:0];
         period_ff <= req_period;
         count_ff <= req_repeat_count;
         forever_ff <= req_forever_req;
         at_ff <= req_fire_at[TB-1:0];
      end
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      match_ff <= match_in;
      match_slot_ff <= match_slot_in;
      free_ff <= free_in;
      free_slot_ff <= free_slot_in;
      any_fired_ff <= any_fired_in;
      pend_id_ff <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_id = rsp_id_ff;
   assign rsp_present = rsp_present_ff && !any_fired_ff;
   assign rsp_last = rsp_last_ff;

endmodule

@@ rtl/core/mts_slot_ram.sv @@
// ----------------------------------------------------------------------------
// Timer slot memory
// Simple dual port synchronous memory for the timer entries, registered read.
// ----------------------------------------------------------------------------
module mts_slot_ram (
   input  logic clock,
   input  logic wr_en,
   input  logic [mts_pkg::SLOT_BITS-1:0] wr_addr,
   input  mts_pkg::slot_type wr_data,
   input  logic [mts_pkg::SLOT_BITS-1:0] rd_addr,
   output mts_pkg::slot_type rd_data
);

   mts_pkg::slot_type mem [mts_pkg::NUM_TIMERS];
   mts_pkg::slot_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mts_checker.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler port checker
// Watches the ports of the timer scheduler over time.
// ----------------------------------------------------------------------------
module mts_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [2:0] rsp_status,
   input logic rsp_present,
   input logic rsp_last
);

   // A stalled result word is held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result word changed");

   // Only query answers carry the present flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_present |-> rsp_status == mts_pkg::ST_QUERY)
      else $error("present flag outside a query answer");

   // Non-fired results are always the last word of their request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mts_pkg::ST_FIRED |-> rsp_last)
      else $error("single result not marked last");

   // The block is idle and ready for a request right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind multi_timer_scheduler mts_checker u_mts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_present(rsp_present),
   .rsp_last   (rsp_last)
);

@@ tb/multi_timer_scheduler_checker.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler checker
// Watches the request and result channels of the timer scheduler, keeps its
// own copy of the timer table and the tick count, works out the result words
// each accepted request must cause, and compares them in order.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic [2:0] req_type,
   input  logic [15:0] req_timer_id,
   input  logic [23:0] req_period,
   input  logic [15:0] req_repeat_count,
   input  logic req_forever_req,
   input  logic [31:0] req_fire_at,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [2:0] rsp_status,
   input  logic [15:0] rsp_out_id,
   input  logic rsp_present,
   input  logic rsp_last,
   output int fail_count,
   output int pending_count,
   output int fired_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0] status;
      logic [15:0] id;
      logic present;
      logic last;
   } answer_type;

   answer_type answers_due[$];

   logic timer_used[mts_pkg::NUM_TIMERS];
   mts_pkg::slot_type timer_tab[mts_pkg::NUM_TIMERS];
   logic [mts_pkg::TIME_BITS-1:0] tick_now;

   // Index of the live slot holding an id, or -1.
   function automatic int slot_of(logic [mts_pkg::ID_BITS-1:0] id);
      for (int i = 0; i < mts_pkg::NUM_TIMERS; i++)
         if (timer_used[i] && timer_tab[i].id == id) return i;
      return -1;
   endfunction

   function automatic void push_answer(logic [2:0] st, logic [15:0] id, logic pres,
                                       logic lst);
      answer_type a;
      a.status = st;
      a.id = id;
      a.present = pres;
      a.last = lst;
      answers_due.push_back(a);
   endfunction

   // Apply one request to the table and queue the result words it causes.
   task automatic apply_request();
      int free_slot;
      int hit;
      int first;
      bit ok;
      first = answers_due.size();
      free_slot = -1;
      for (int i = mts_pkg::NUM_TIMERS - 1; i >= 0; i--)
         if (!timer_used[i]) free_slot = i;
      hit = slot_of(req_timer_id);
      case (req_type)
         mts_pkg::REQ_TICK: begin
            tick_now = tick_now + 1;
            for (int i = 0; i < mts_pkg::NUM_TIMERS; i++) begin
               if (timer_used[i] && timer_tab[i].fire_time <= tick_now) begin
                  push_answer(mts_pkg::ST_FIRED, timer_tab[i].id, 1'b0, 1'b0);
                  if (timer_tab[i].period != 0) begin
                     timer_tab[i].fire_time =
                        tick_now + mts_pkg::TIME_BITS'(timer_tab[i].period);
                     if (!timer_tab[i].forever_flag) begin
                        if (timer_tab[i].remaining <= 1) timer_used[i] = 1'b0;
                        else timer_tab[i].remaining--;
                     end
                  end else begin
                     timer_used[i] = 1'b0;
                  end
               end
            end
            if (answers_due.size() > first)
               answers_due[answers_due.size() - 1].last = 1'b1;
         end
         mts_pkg::REQ_ADD_PER, mts_pkg::REQ_ADD_ONE: begin
            ok = (hit < 0) && (free_slot >= 0);
            if (req_type == mts_pkg::REQ_ADD_PER) ok = ok && req_period != 0;
            else ok = ok && req_fire_at > tick_now;
            if (ok) begin
               timer_used[free_slot] = 1'b1;
               timer_tab[free_slot].id = req_timer_id;
               if (req_type == mts_pkg::REQ_ADD_PER) begin
                  timer_tab[free_slot].period = req_period;
                  timer_tab[free_slot].remaining = req_repeat_count;
                  timer_tab[free_slot].forever_flag = req_forever_req;
                  timer_tab[free_slot].fire_time =
                     tick_now + mts_pkg::TIME_BITS'(req_period);
               end else begin
                  timer_tab[free_slot].period = '0;
                  timer_tab[free_slot].remaining = 16'd1;
                  timer_tab[free_slot].forever_flag = 1'b0;
                  timer_tab[free_slot].fire_time = req_fire_at;
               end
            end
            push_answer(ok ? mts_pkg::ST_ADDED : mts_pkg::ST_REJECTED, req_timer_id,
                        1'b0, 1'b1);
         end
         mts_pkg::REQ_KILL: begin
            if (hit >= 0) timer_used[hit] = 1'b0;
            push_answer(hit >= 0 ? mts_pkg::ST_KILLED : mts_pkg::ST_NOT_FOUND,
                        req_timer_id, 1'b0, 1'b1);
         end
         mts_pkg::REQ_QUERY: push_answer(mts_pkg::ST_QUERY, req_timer_id, hit >= 0, 1'b1);
         default: ;
      endcase
   endtask

   // Sample both channels at each rising edge.
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         answers_due.delete();
         for (int i = 0; i < mts_pkg::NUM_TIMERS; i++) begin
            timer_used[i] = 1'b0;
            timer_tab[i] = '0;
         end
         tick_now = '0;
         fail_count = 0;
         fired_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_status == mts_pkg::ST_FIRED) fired_count++;
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word status=%0d id=%0h", $realtime,
                           rsp_status, rsp_out_id);
            end else begin
               want = answers_due.pop_front();
               if (want !== {rsp_status, rsp_out_id, rsp_present, rsp_last}) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch expected st=%0d id=%0h pres=%0b last=%0b",
                              $realtime, want.status, want.id, want.present, want.last);
                     $display("   got st=%0d id=%0h pres=%0b last=%0b",
                              rsp_status, rsp_out_id, rsp_present, rsp_last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) apply_request();
      end
      pending_count = answers_due.size();
   end

endmodule

@@ tb/multi_timer_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// Timer scheduler testbench
// Drives directed and random timer requests with random idle cycles on both
// channels; a checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_type;
   logic [15:0] req_timer_id;
   logic [23:0] req_period;
   logic [15:0] req_repeat_count;
   logic req_forever_req;
   logic [31:0] req_fire_at;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_status;
   logic [15:0] rsp_out_id;
   logic rsp_present;
   logic rsp_last;
   int fail_count;
   int pending_count;
   int fired_count;
   int idle_pct;
   int words_sent;
   int quiet_cycles;
   logic [31:0] model_now;

   multi_timer_scheduler i_dut (.*);
   multi_timer_scheduler_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side stalls at random.
   initial rsp_stall = 1'b0;
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < idle_pct);

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_CYCLES) begin
         $display("multi_timer_scheduler_tb failed");
         $finish;
      end
   end

   // Present one request word and hold it until it is taken.
   task automatic send_word(logic [2:0] kind, logic [15:0] id, logic [23:0] per,
                            logic [15:0] cnt, logic fv, logic [31:0] at);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_timer_id <= id;
      req_period <= per;
      req_repeat_count <= cnt;
      req_forever_req <= fv;
      req_fire_at <= at;
      do @(posedge clock); while (req_stall);
      if (kind == mts_pkg::REQ_TICK) model_now++;
      words_sent++;
   endtask

   // A random request, mostly on a small id pool so adds, kills and firings meet.
   task automatic send_random();
      logic [2:0] kind;
      logic [15:0] id;
      logic [23:0] per;
      logic [31:0] at;
      int pick;
      pick = $urandom_range(99);
      kind = pick < 35 ? mts_pkg::REQ_TICK : pick < 55 ? mts_pkg::REQ_ADD_PER :
             pick < 70 ? mts_pkg::REQ_ADD_ONE : pick < 82 ? mts_pkg::REQ_KILL :
             pick < 96 ? mts_pkg::REQ_QUERY : 3'($urandom_range(7, 5));
      id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
      per = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(6));
      at = ($urandom_range(9) == 0) ? $urandom : model_now + $urandom_range(8) - 1;
      send_word(kind, id, per, 16'($urandom_range(9) == 0 ? $urandom : $urandom_range(4)),
                1'($urandom), at);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = mts_pkg::REQ_TICK;
      req_timer_id = '0;
      req_period = '0;
      req_repeat_count = '0;
      req_forever_req = 1'b0;
      req_fire_at = '0;
      idle_pct = 24;
      words_sent = 0;
      quiet_cycles = 0;
      model_now = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: rejections, extremes, kill, query, unknown codes, full table.
      send_word(mts_pkg::REQ_ADD_PER, 16'h0001, '0, 16'd3, 1'b0, '0);
      send_word(mts_pkg::REQ_ADD_ONE, 16'h0002, '0, '0, 1'b0, 32'd0);
      send_word(mts_pkg::REQ_ADD_PER, 16'hFFFF, 24'd1, 16'd0, 1'b0, 32'hFFFF_FFFF);
      send_word(mts_pkg::REQ_ADD_PER, 16'hFFFF, 24'd2, 16'd2, 1'b0, '0);
      send_word(mts_pkg::REQ_ADD_PER, 16'h0000, 24'hFF_FFFF, 16'hFFFF, 1'b1, '0);
      send_word(mts_pkg::REQ_ADD_ONE, 16'h0003, '0, '0, 1'b0, 32'hFFFF_FFFF);
      send_word(mts_pkg::REQ_ADD_ONE, 16'h0004, '0, '0, 1'b0, 32'd1);
      send_word(mts_pkg::REQ_ADD_PER, 16'h0005, 24'd1, 16'd2, 1'b1, '0);
      send_word(mts_pkg::REQ_QUERY, 16'h0004, '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_KILL, 16'h0005, '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_KILL, 16'h0005, '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_QUERY, 16'h0005, '0, '0, 1'b0, '0);
      send_word(3'd5, 16'hAAAA, 24'h55_5555, 16'h5555, 1'b1, 32'hAAAA_AAAA);
      send_word(3'd7, '0, '0, '0, 1'b0, '0);
      for (int i = 0; i < 16; i++)
         send_word(mts_pkg::REQ_ADD_ONE, 16'(16'h0100 + i), '0, '0, 1'b0, 32'd100);
      for (int i = 0; i < 4; i++) send_word(mts_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      for (int i = 0; i < 16; i++)
         send_word(mts_pkg::REQ_KILL, 16'(16'h0100 + i), '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_KILL, 16'h0000, '0, '0, 1'b0, '0);
      send_word(mts_pkg::REQ_KILL, 16'h0003, '0, '0, 1'b0, '0);

      // Random: a stretch with no idling in the middle.
      for (int n = 0; n < 422; n++) begin
         idle_pct = (n >= 200 && n < 280) ? 0 : 24;
         send_random();
      end
      req_valid <= 1'b0;
      idle_pct = 24;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d request words; %0d timer firings checked among the results.",
               words_sent, fired_count);
      if (fail_count == 0 && pending_count == 0) $display("multi_timer_scheduler_tb passed");
      else $display("multi_timer_scheduler_tb failed");
      $finish;
   end

endmodule
